// ===== src/hwss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hwss_pkg
// Shared constants, types and state encodings of the hue weighted saturation
// scorer.
// ----------------------------------------------------------------------------
package hwss_pkg;

    localparam int MAX_PIXELS  = 262144;
    localparam int HUE_ENTRIES = 180;
    localparam int IDX_W       = 8;
    localparam int WGT_W       = 9;
    localparam int CH_W        = 8;
    localparam int RAMP_W      = 7;
    localparam int PROD_W      = 15;
    localparam int SCORE_W     = 8;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int SUM_W       = 33;
    localparam int FRAME_DEN   = 25;
    localparam int CNT_W       = $clog2(MAX_PIXELS + 1);
    localparam int DEN_W       = $clog2(MAX_PIXELS * FRAME_DEN + 1);
    localparam int NUM_W       = SUM_W + 8;
    localparam int QUOT_W      = 16;
    localparam int STEP_W      = $clog2(QUOT_W);
    localparam int IN_W        = 40;
    localparam int OUT_W       = 24;

    localparam logic [WGT_W-1:0]   WEIGHT_ONE   = 9'd256;
    localparam logic [WGT_W-1:0]   WEIGHT_RESET = 9'd64;
    localparam logic [CH_W-1:0]    SAT_FLOOR    = 8'd100;
    localparam logic [CH_W-1:0]    DARK_LIMIT   = 8'd32;
    localparam logic [RAMP_W-1:0]  SAT_SPAN     = 7'd100;
    localparam logic [RECIP_W-1:0] RECIP_100    = 13'd5243;
    localparam logic [QUOT_W-1:0]  QUOT_MAX     = 16'hFFFF;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_SCORE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_SCALE,
        ST_DIV,
        ST_PUSH
    } state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHK,
        DV_RUN
    } div_state_t;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [IDX_W-1:0] addr;
        logic [WGT_W-1:0] data;
    } tab_req_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_res_t;

endpackage
`default_nettype wire

// ===== src/hwss_wtab.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hwss_wtab
// Hue weight table: 180 x 9 bit synchronous memory with a registered read.
// Per-entry valid bits make unwritten entries read as the reset weight.
// ----------------------------------------------------------------------------
module hwss_wtab
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire hwss_pkg::tab_req_t        req,
    output logic [hwss_pkg::WGT_W-1:0]     rd_data
);

    logic [hwss_pkg::WGT_W-1:0]       mem [0:hwss_pkg::HUE_ENTRIES-1];
    logic [hwss_pkg::HUE_ENTRIES-1:0] valid_reg;
    logic                             rd_valid_reg;
    logic [hwss_pkg::WGT_W-1:0]       rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : hwss_pkg::WEIGHT_RESET;

endmodule
`default_nettype wire

// ===== src/hwss_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hwss_div
// Serial restoring divider for the frame score: an overflow check state,
// then one quotient bit per cycle. Quotient saturates at 16 bits.
// ----------------------------------------------------------------------------
module hwss_div
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hwss_pkg::div_req_t req,
    output hwss_pkg::div_res_t      res
);

    hwss_pkg::div_state_t             state_reg;
    hwss_pkg::div_state_t             state_next;
    logic [hwss_pkg::NUM_W-1:0]       num_reg;
    logic [hwss_pkg::DEN_W-1:0]       den_reg;
    logic [hwss_pkg::DEN_W-1:0]       rem_reg;
    logic [hwss_pkg::DEN_W-1:0]       rem_next;
    logic [hwss_pkg::QUOT_W-1:0]      quot_reg;
    logic [hwss_pkg::STEP_W-1:0]      step_reg;
    logic                             done_reg;
    logic [hwss_pkg::QUOT_W-1:0]      num_lo;
    logic [hwss_pkg::DEN_W:0]         trial;
    logic                             ge;
    logic                             ovf;
    logic                             load;
    logic                             finish;

    assign num_lo = num_reg[hwss_pkg::QUOT_W-1:0];
    assign ovf    = num_reg[hwss_pkg::NUM_W-1:hwss_pkg::QUOT_W] >= den_reg;
    assign trial  = {rem_reg, num_lo[step_reg]};
    assign ge     = trial >= {1'b0, den_reg};

    always_comb
    begin
        if (ge)
        begin
            rem_next = hwss_pkg::DEN_W'(trial - {1'b0, den_reg});
        end
        else
        begin
            rem_next = hwss_pkg::DEN_W'(trial);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hwss_pkg::DV_IDLE:
            begin
                if (req.start)
                begin
                    state_next = hwss_pkg::DV_CHK;
                end
            end
            hwss_pkg::DV_CHK:
            begin
                state_next = ovf ? hwss_pkg::DV_IDLE : hwss_pkg::DV_RUN;
            end
            hwss_pkg::DV_RUN:
            begin
                if (step_reg == '0)
                begin
                    state_next = hwss_pkg::DV_IDLE;
                end
            end
            default:
            begin
                state_next = hwss_pkg::DV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load   = 1'b0;
        finish = 1'b0;
        unique case (state_reg)
            hwss_pkg::DV_IDLE: load   = req.start;
            hwss_pkg::DV_CHK:  finish = ovf;
            hwss_pkg::DV_RUN:  finish = (step_reg == '0);
            default:
            begin
                load   = 1'b0;
                finish = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hwss_pkg::DV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
        end
        if (state_reg == hwss_pkg::DV_CHK)
        begin
            rem_reg  <= hwss_pkg::DEN_W'(num_reg[hwss_pkg::NUM_W-1:hwss_pkg::QUOT_W]);
            step_reg <= hwss_pkg::STEP_W'(hwss_pkg::QUOT_W - 1);
            quot_reg <= ovf ? hwss_pkg::QUOT_MAX : '0;
        end
        else if (state_reg == hwss_pkg::DV_RUN)
        begin
            rem_reg  <= rem_next;
            step_reg <= step_reg - 1'b1;
            quot_reg <= {quot_reg[hwss_pkg::QUOT_W-2:0], ge};
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule
`default_nettype wire

// ===== src/hue_weighted_saturation_score.sv =====
// Path from accept to output register load: a weight write goes straight to
// push; a scored pixel passes mul, acc and scale; a frame-end pixel also
// waits in div for the serial divider (overflow check plus 16 quotient
// steps, or the check alone when the quotient overflows). A new request is
// taken only in idle, after the last one is pushed. A stalled output holds the block in push.
// Reset: weight table reads 0.25 through per-entry valid bits, no clearing
// pass; frame sum and pixel count cleared at once.
`default_nettype none
// ----------------------------------------------------------------------------
// hue_weighted_saturation_score
// Stores hue weights, scores pixels by hue weight times saturation ramp and
// emits the frame colour factor on the last pixel of a frame.
// ----------------------------------------------------------------------------
module hue_weighted_saturation_score
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // hue[7:0], saturation[15:8], brightness[23:16], weight[32:24], zero pad
    input  wire logic [hwss_pkg::IN_W-1:0] s_tdata,
    // func
    input  wire logic                      s_tuser,
    // last_pixel
    input  wire logic                      s_tlast,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // pixel_score[7:0], frame_score[23:8]
    output logic [hwss_pkg::OUT_W-1:0]     m_tdata,
    // frame_valid
    output logic                           m_tuser
);

    hwss_pkg::state_t                  state_reg;
    hwss_pkg::state_t                  state_next;
    hwss_pkg::tab_req_t                tab_req;
    hwss_pkg::div_req_t                div_req;
    hwss_pkg::div_res_t                div_res;
    logic [hwss_pkg::WGT_W-1:0]        rd_weight;

    logic [hwss_pkg::IDX_W-1:0]        in_hue;
    logic [hwss_pkg::CH_W-1:0]         in_sat;
    logic [hwss_pkg::CH_W-1:0]         in_bri;
    logic [hwss_pkg::WGT_W-1:0]        in_wgt;
    logic                              accept;
    logic                              hue_ok;
    logic [hwss_pkg::CH_W-1:0]         sat_off;
    logic [hwss_pkg::RAMP_W-1:0]       ramp_next;
    logic                              out_free;
    logic                              load_out;

    logic                              hue_ok_reg;
    logic [hwss_pkg::RAMP_W-1:0]       ramp_reg;
    logic                              last_reg;
    logic [hwss_pkg::PROD_W-1:0]       prod_reg;
    logic [hwss_pkg::PROD_W-1:0]       prod_next;
    logic [hwss_pkg::WGT_W-1:0]        w_sel;
    logic [hwss_pkg::PROD_W+7:0]       prod_x255;
    logic [hwss_pkg::PROD_W-1:0]       y_reg;
    logic [hwss_pkg::PROD_W+hwss_pkg::RECIP_W-1:0] y_mul;
    logic [hwss_pkg::SCORE_W-1:0]      score_reg;
    logic [hwss_pkg::QUOT_W-1:0]       frame_reg;

    logic [hwss_pkg::SUM_W-1:0]        sum_reg;
    logic [hwss_pkg::SUM_W-1:0]        sum_next;
    logic [hwss_pkg::SUM_W:0]          sum_add;
    logic [hwss_pkg::CNT_W-1:0]        count_reg;
    logic [hwss_pkg::CNT_W-1:0]        count_next;

    logic                              m_tvalid_reg;
    logic [hwss_pkg::OUT_W-1:0]        m_tdata_reg;
    logic                              m_tuser_reg;

    assign in_hue = s_tdata[7:0];
    assign in_sat = s_tdata[15:8];
    assign in_bri = s_tdata[23:16];
    assign in_wgt = s_tdata[32:24];
    assign accept = s_tvalid && s_tready;
    assign hue_ok = in_hue < hwss_pkg::IDX_W'(hwss_pkg::HUE_ENTRIES);

    assign sat_off = in_sat - hwss_pkg::SAT_FLOOR;
    always_comb
    begin
        if (in_sat < hwss_pkg::SAT_FLOOR || in_bri < hwss_pkg::DARK_LIMIT)
        begin
            ramp_next = '0;
        end
        else if (sat_off > hwss_pkg::CH_W'(hwss_pkg::SAT_SPAN))
        begin
            ramp_next = hwss_pkg::SAT_SPAN;
        end
        else
        begin
            ramp_next = hwss_pkg::RAMP_W'(sat_off);
        end
    end

    // weight table port
    always_comb
    begin
        tab_req.wr_en = accept && (s_tuser == hwss_pkg::FUNC_WRITE) && hue_ok;
        tab_req.rd_en = accept && (s_tuser == hwss_pkg::FUNC_SCORE) && hue_ok;
        tab_req.addr  = in_hue;
        tab_req.data  = (in_wgt > hwss_pkg::WEIGHT_ONE) ? hwss_pkg::WEIGHT_ONE : in_wgt;
    end

    hwss_wtab u_wtab
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tab_req),
        .rd_data (rd_weight)
    );

    assign w_sel     = hue_ok_reg ? rd_weight : '0;
    assign prod_next = hwss_pkg::PROD_W'(w_sel * ramp_reg);

    // x*255/256, then /100 by reciprocal (exact for y below 43699)
    assign prod_x255 = {prod_reg, 8'b0} - (hwss_pkg::PROD_W+8)'(prod_reg);
    assign y_mul     = y_reg * hwss_pkg::RECIP_100;

    assign sum_add = {1'b0, sum_reg} + (hwss_pkg::SUM_W+1)'(prod_reg);
    always_comb
    begin
        sum_next   = sum_add[hwss_pkg::SUM_W] ? '1 : sum_add[hwss_pkg::SUM_W-1:0];
        count_next = count_reg;
        if (count_reg < hwss_pkg::CNT_W'(hwss_pkg::MAX_PIXELS))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // frame score = floor(sum*192 / (count*25))
    always_comb
    begin
        div_req.start = (state_reg == hwss_pkg::ST_SCALE) && last_reg;
        div_req.num   = hwss_pkg::NUM_W'({sum_reg, 7'b0}) + hwss_pkg::NUM_W'({sum_reg, 6'b0});
        div_req.den   = hwss_pkg::DEN_W'(count_reg) * hwss_pkg::DEN_W'(hwss_pkg::FRAME_DEN);
    end

    hwss_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hwss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (s_tuser == hwss_pkg::FUNC_SCORE) ? hwss_pkg::ST_MUL
                                                                    : hwss_pkg::ST_PUSH;
                end
            end
            hwss_pkg::ST_MUL:   state_next = hwss_pkg::ST_ACC;
            hwss_pkg::ST_ACC:   state_next = hwss_pkg::ST_SCALE;
            hwss_pkg::ST_SCALE: state_next = last_reg ? hwss_pkg::ST_DIV : hwss_pkg::ST_PUSH;
            hwss_pkg::ST_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = hwss_pkg::ST_PUSH;
                end
            end
            hwss_pkg::ST_PUSH:
            begin
                if (out_free)
                begin
                    state_next = hwss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hwss_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            hwss_pkg::ST_IDLE:  s_tready = 1'b1;
            hwss_pkg::ST_PUSH:  load_out = out_free;
            hwss_pkg::ST_MUL,
            hwss_pkg::ST_ACC,
            hwss_pkg::ST_SCALE,
            hwss_pkg::ST_DIV:
            begin
                s_tready = 1'b0;
                load_out = 1'b0;
            end
            default:
            begin
                s_tready = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= hwss_pkg::ST_IDLE;
            sum_reg      <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == hwss_pkg::ST_ACC)
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
            else if (div_req.start)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hue_ok_reg <= hue_ok;
            ramp_reg   <= ramp_next;
            last_reg   <= s_tlast && (s_tuser == hwss_pkg::FUNC_SCORE);
            score_reg  <= '0;
            frame_reg  <= '0;
        end
        if (state_reg == hwss_pkg::ST_MUL)
        begin
            prod_reg <= prod_next;
        end
        if (state_reg == hwss_pkg::ST_ACC)
        begin
            y_reg <= prod_x255[hwss_pkg::PROD_W+7:8];
        end
        if (state_reg == hwss_pkg::ST_SCALE)
        begin
            score_reg <= y_mul[hwss_pkg::RECIP_SHIFT +: hwss_pkg::SCORE_W];
        end
        if (state_reg == hwss_pkg::ST_DIV && div_res.done)
        begin
            frame_reg <= div_res.quot;
        end
        if (load_out)
        begin
            m_tdata_reg <= {frame_reg, score_reg};
            m_tuser_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[23:8] == '0)
        else $error("frame score nonzero without frame_valid");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in flight");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hwss_pkg::CNT_W'(hwss_pkg::MAX_PIXELS))
        else $error("pixel count beyond its ceiling");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == hwss_pkg::ST_DIV)
        else $error("divider finished outside frame-end wait");

    a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hwss_pkg::ST_PUSH && m_tvalid && !m_tready
        |=> state_reg == hwss_pkg::ST_PUSH)
        else $error("result dropped while output stalled");
`endif

endmodule
`default_nettype wire
